// ----- rtl/core/stack_machine_step_top_assert.svh -----
// Assertion macros shared by the stack machine checker.
// No dependencies beyond the including file's clock and reset names.
`ifndef STACK_MACHINE_STEP_TOP_ASSERT_SVH
`define STACK_MACHINE_STEP_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stack machine check failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define SMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stack machine check failed");
`endif

// ----- rtl/core/sms_pkg.sv -----
// Package for the stack machine step block: opcodes, fault codes, divider handshake structs.
// No dependencies.
`default_nettype none
package sms_pkg;
  typedef enum logic [3:0] {
    OP_NOP = 4'd0, OP_PUSH = 4'd1, OP_POP = 4'd2, OP_JMP = 4'd3, OP_JMPIF = 4'd4,
    OP_ADD = 4'd5, OP_SUB = 4'd6, OP_MUL = 4'd7, OP_DIV = 4'd8, OP_DUP = 4'd9,
    OP_SWAP = 4'd10, OP_LABEL = 4'd11, OP_HALT = 4'd12, OP_INVALID = 4'd13
  } op_e;

  localparam logic [1:0] FAULT_OK   = 2'd0;
  localparam logic [1:0] FAULT_OVER = 2'd1;
  localparam logic [1:0] FAULT_UNDR = 2'd2;
  localparam logic [1:0] FAULT_DIV0 = 2'd3;

  // Divider handshake.
  typedef struct packed {
    logic start;
  } div_ctl_t;
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage
`default_nettype wire

// ----- rtl/core/sms_div.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Uses sms_pkg for the control structs.
`default_nettype none
module sms_div #(
  parameter int unsigned W = 32
) (
  input  wire  logic           clk_i,
  input  wire  logic           rst_ni,
  input  wire  sms_pkg::div_ctl_t ctl_i,
  input  wire  logic [W-1:0]   a_i,
  input  wire  logic [W-1:0]   b_i,
  output sms_pkg::div_sts_t    sts_o,
  output logic [W-1:0]         q_o
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  q_q, q_d, d_q, d_d;
  logic [W:0]    r_q, r_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    q_d = q_q; d_d = d_q; r_d = r_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; neg_d = neg_q;
    shifted = {r_q[W-1:0], q_q[W-1]};
    trial = shifted - {1'b0, d_q};
    if (ctl_i.start) begin
      q_d = a_i[W-1] ? (~a_i + 1'b1) : a_i;
      d_d = b_i[W-1] ? (~b_i + 1'b1) : b_i;
      r_d = '0;
      cnt_d = CW'(W);
      busy_d = 1'b1;
      neg_d = a_i[W-1] ^ b_i[W-1];
    end else if (busy_q) begin
      if (!trial[W]) begin
        r_d = trial;
        q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = shifted;
        q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; d_q <= d_d; r_q <= r_d; neg_q <= neg_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign q_o = neg_q ? (~q_q + 1'b1) : q_q;
endmodule
`default_nettype wire

// ----- rtl/core/sms_mem.sv -----
// Stack memory: one write port and one registered read port.
// No package dependencies.
`default_nettype none
module sms_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned W     = 40
) (
  input  wire  logic                     clk_i,
  input  wire  logic                     we_i,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  logic [W-1:0]             wdata_i,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]                   rdata_o
);
  logic [W-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/stack_machine_step_top.sv -----
// Stack machine step: top level with sequencer, stack memory and divider.
// Uses sms_pkg, sms_mem and sms_div.
//
// One instruction per start; busy stays high until the result strobe. The
// top two entries are read from the single read port of the stack memory,
// one after the other; then the execute state writes back and the top state
// picks the new top. Swap needs a second write-back state and jmp_if a third
// memory read, and div waits for the bit-serial divider. The next start is
// taken in the cycle that shows done_o, so no new instruction is taken before
// the last one is through. Results are shown for one cycle with done_o and
// cannot be held off by the receiver.
`default_nettype none
module stack_machine_step_top #(
  parameter int unsigned STACK_DEPTH  = 1024,
  parameter int unsigned VALUE_WIDTH  = 32,
  parameter int unsigned SYMBOL_WIDTH = 8,
  parameter int unsigned IP_WIDTH     = 16
) (
  input  wire  logic                       clk_i,
  input  wire  logic                       rst_ni,
  input  wire  logic                       start,
  output logic                             busy,
  output logic                             done_o,
  input  wire  logic [3:0]                 cmd_i,
  input  wire  logic signed [VALUE_WIDTH-1:0] operand_value_i,
  input  wire  logic [SYMBOL_WIDTH-1:0]    operand_symbol_i,
  output logic signed [VALUE_WIDTH-1:0]    top_value_o,
  output logic [SYMBOL_WIDTH-1:0]          top_symbol_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0] stack_count_o,
  output logic [IP_WIDTH-1:0]              next_ip_o,
  output logic [1:0]                       fault_o
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = VALUE_WIDTH + SYMBOL_WIDTH;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_RD1 = 8'b00000010, S_RD2 = 8'b00000100,
    S_EXEC = 8'b00001000, S_DIV = 8'b00010000, S_WB2 = 8'b00100000,
    S_TOP  = 8'b01000000, S_DONE = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [IP_WIDTH-1:0] pc_q, pc_d;
  logic [3:0] cmd_q;
  logic [VALUE_WIDTH-1:0] pv_q;
  logic [SYMBOL_WIDTH-1:0] ps_q;
  logic [EW-1:0] b_q, b_d, a_q, a_d;
  logic [1:0] fault_q, fault_d;
  logic [EW-1:0] top_q, top_d;
  logic [EW-1:0] w2_q, w2_d;
  logic [AW-1:0] w2a_q, w2a_d;
  logic done_q, done_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  sms_pkg::div_ctl_t dctl;
  sms_pkg::div_sts_t dsts;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] prod;
  logic [1:0] need;
  logic is_push_dup;

  sms_mem #(.DEPTH(STACK_DEPTH), .W(EW)) u_mem (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  sms_div #(.W(VALUE_WIDTH)) u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(dctl),
    .a_i(a_q[EW-1 -: VALUE_WIDTH]), .b_i(b_q[EW-1 -: VALUE_WIDTH]),
    .sts_o(dsts), .q_o(quo)
  );

  assign prod = a_q[EW-1 -: VALUE_WIDTH] * b_q[EW-1 -: VALUE_WIDTH];

  always_comb begin
    unique case (sms_pkg::op_e'(cmd_q))
      sms_pkg::OP_POP, sms_pkg::OP_JMP, sms_pkg::OP_DUP: need = 2'd1;
      sms_pkg::OP_JMPIF, sms_pkg::OP_ADD, sms_pkg::OP_SUB, sms_pkg::OP_MUL,
      sms_pkg::OP_DIV, sms_pkg::OP_SWAP: need = 2'd2;
      default: need = 2'd0;
    endcase
    is_push_dup = (cmd_q == sms_pkg::OP_PUSH) || (cmd_q == sms_pkg::OP_DUP);
  end

  // Entries hold {value, symbol}; reads address sp-1 then sp-2.
  always_comb begin
    state_d = state_q; sp_d = sp_q; pc_d = pc_q; b_d = b_q; a_d = a_q;
    fault_d = fault_q; top_d = top_q; w2_d = w2_q; w2a_d = w2a_q;
    done_d = 1'b0; we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    dctl.start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        raddr = AW'(sp_q - 1'b1);
        if (start) state_d = S_RD1;
      end
      S_RD1: begin
        b_d = rdata;
        raddr = AW'(sp_q - CW'(2));
        state_d = S_RD2;
      end
      S_RD2: begin
        a_d = rdata;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        fault_d = sms_pkg::FAULT_OK;
        state_d = S_TOP;
        if (sp_q < CW'(need)) begin
          fault_d = sms_pkg::FAULT_UNDR;
        end else if (is_push_dup && sp_q >= CW'(STACK_DEPTH)) begin
          fault_d = sms_pkg::FAULT_OVER;
        end else if (cmd_q == sms_pkg::OP_DIV && b_q[EW-1 -: VALUE_WIDTH] == '0) begin
          fault_d = sms_pkg::FAULT_DIV0;
        end else begin
          unique case (sms_pkg::op_e'(cmd_q))
            sms_pkg::OP_NOP: pc_d = pc_q + 1'b1;
            sms_pkg::OP_PUSH: begin
              we = 1'b1; waddr = AW'(sp_q); wdata = {pv_q, ps_q};
              sp_d = sp_q + 1'b1; pc_d = pc_q + 1'b1;
            end
            sms_pkg::OP_POP: begin
              sp_d = sp_q - 1'b1; pc_d = pc_q + 1'b1;
            end
            sms_pkg::OP_JMP: begin
              pc_d = b_q[SYMBOL_WIDTH +: IP_WIDTH];
              sp_d = sp_q - 1'b1;
            end
            sms_pkg::OP_JMPIF: begin
              sp_d = sp_q - CW'(2);
              pc_d = (a_q[EW-1 -: VALUE_WIDTH] != '0) ?
                     b_q[SYMBOL_WIDTH +: IP_WIDTH] : pc_q + 1'b1;
            end
            sms_pkg::OP_ADD, sms_pkg::OP_SUB, sms_pkg::OP_MUL: begin
              we = 1'b1; waddr = AW'(sp_q - CW'(2));
              unique case (sms_pkg::op_e'(cmd_q))
                sms_pkg::OP_ADD: wdata[EW-1 -: VALUE_WIDTH] =
                  a_q[EW-1 -: VALUE_WIDTH] + b_q[EW-1 -: VALUE_WIDTH];
                sms_pkg::OP_SUB: wdata[EW-1 -: VALUE_WIDTH] =
                  a_q[EW-1 -: VALUE_WIDTH] - b_q[EW-1 -: VALUE_WIDTH];
                default: wdata[EW-1 -: VALUE_WIDTH] = prod;
              endcase
              wdata[SYMBOL_WIDTH-1:0] = a_q[SYMBOL_WIDTH-1:0];
              a_d = wdata;
              sp_d = sp_q - 1'b1; pc_d = pc_q + 1'b1;
            end
            sms_pkg::OP_DIV: begin
              dctl.start = 1'b1;
              state_d = S_DIV;
            end
            sms_pkg::OP_DUP: begin
              we = 1'b1; waddr = AW'(sp_q); wdata = b_q;
              sp_d = sp_q + 1'b1; pc_d = pc_q + 1'b1;
            end
            sms_pkg::OP_SWAP: begin
              we = 1'b1; waddr = AW'(sp_q - 1'b1); wdata = a_q;
              w2_d = b_q; w2a_d = AW'(sp_q - CW'(2));
              pc_d = pc_q + 1'b1;
              state_d = S_WB2;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (dsts.done) begin
          we = 1'b1; waddr = AW'(sp_q - CW'(2));
          wdata = {quo, a_q[SYMBOL_WIDTH-1:0]};
          a_d = wdata;
          sp_d = sp_q - 1'b1; pc_d = pc_q + 1'b1;
          state_d = S_TOP;
        end
      end
      S_WB2: begin
        we = 1'b1; waddr = w2a_q; wdata = w2_q;
        state_d = S_TOP;
      end
      S_TOP: begin
        // Except for jmp_if, which reads the new top from memory, the new top
        // is chosen from the operands and the pushed entry.
        priority if (fault_q != sms_pkg::FAULT_OK) top_d = b_q;
        else if (cmd_q == sms_pkg::OP_PUSH) top_d = {pv_q, ps_q};
        else if (cmd_q == sms_pkg::OP_ADD || cmd_q == sms_pkg::OP_SUB ||
                 cmd_q == sms_pkg::OP_MUL || cmd_q == sms_pkg::OP_DIV) top_d = a_q;
        else if (cmd_q == sms_pkg::OP_POP || cmd_q == sms_pkg::OP_JMP) top_d = a_q;
        else if (cmd_q == sms_pkg::OP_SWAP) top_d = a_q;
        else if (cmd_q == sms_pkg::OP_JMPIF) begin
          raddr = AW'(sp_q - 1'b1);
          top_d = '0;
        end else top_d = b_q;
        state_d = (cmd_q == sms_pkg::OP_JMPIF && fault_q == sms_pkg::FAULT_OK) ?
                  S_DONE : S_IDLE;
        done_d = !(cmd_q == sms_pkg::OP_JMPIF && fault_q == sms_pkg::FAULT_OK);
      end
      S_DONE: begin
        // jmp_if exposes the entry two below the old top; it is read here.
        top_d = rdata;
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_TOP && cmd_q == sms_pkg::OP_JMPIF &&
        fault_q == sms_pkg::FAULT_OK) begin
      raddr = AW'(sp_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      pc_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      pc_q    <= pc_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q <= cmd_i;
      pv_q  <= operand_value_i;
      ps_q  <= operand_symbol_i;
    end
    b_q <= b_d; a_q <= a_d; fault_q <= fault_d; top_q <= top_d;
    w2_q <= w2_d; w2a_q <= w2a_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign top_value_o   = (sp_q == '0) ? '0 : top_q[EW-1 -: VALUE_WIDTH];
  assign top_symbol_o  = (sp_q == '0) ? '0 : top_q[SYMBOL_WIDTH-1:0];
  assign stack_count_o = sp_q;
  assign next_ip_o     = pc_q;
  assign fault_o       = fault_q;
endmodule
`default_nettype wire

// ----- rtl/core/sms_checker.sv -----
// Port-level checker for stack_machine_step_top, bound to the top level.
// Uses the macros in stack_machine_step_top_assert.svh.
`default_nettype none
`include "stack_machine_step_top_assert.svh"
module sms_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [10:0] stack_count_o,
  input wire logic [1:0]  fault_o
);
  `SMS_ASSERT_NXT(a_start_busy, start && !busy, busy)
  // A start in the result cycle is taken at once, so only an idle sender sees busy low.
  `SMS_ASSERT_NXT(a_done_idle, done_o && !start, !busy)
  `SMS_ASSERT_IMP(a_count_range, 1'b1, stack_count_o <= 11'd1024)
  `SMS_ASSERT_IMP(a_fault_known, done_o, !$isunknown(fault_o))
endmodule
bind stack_machine_step_top sms_checker u_sms_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done_o),
  .stack_count_o(stack_count_o), .fault_o(fault_o)
);
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for stack_machine_step_top: directed and random instruction streams.
// Depends on sms_pkg and the stack_machine_step_top RTL; predicts every step in place.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned DEPTH = 1024;

  typedef struct {
    logic signed [31:0] value;
    logic [7:0]         symbol;
    logic [10:0]        count;
    logic [15:0]        ip;
    logic [1:0]         fault;
  } step_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               done_o;
  logic [3:0]         cmd_i;
  logic signed [31:0] operand_value_i;
  logic [7:0]         operand_symbol_i;
  logic signed [31:0] top_value_o;
  logic [7:0]         top_symbol_o;
  logic [10:0]        stack_count_o;
  logic [15:0]        next_ip_o;
  logic [1:0]         fault_o;

  stack_machine_step_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .done_o           (done_o),
    .cmd_i            (cmd_i),
    .operand_value_i  (operand_value_i),
    .operand_symbol_i (operand_symbol_i),
    .top_value_o      (top_value_o),
    .top_symbol_o     (top_symbol_o),
    .stack_count_o    (stack_count_o),
    .next_ip_o        (next_ip_o),
    .fault_o          (fault_o)
  );

  // Shadow copy of the machine state.
  logic signed [31:0] shadow_value [DEPTH];
  logic [7:0]         shadow_symbol [DEPTH];
  int unsigned        shadow_depth;
  logic [15:0]        shadow_ip;

  step_result_t expected_steps[$];
  int unsigned  mismatch_count;
  int unsigned  idle_pct;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [31:0] quotient_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ua;
    logic [31:0] ub;
    logic [31:0] q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    if (a[31] ^ b[31]) q = -q;
    return q;
  endfunction

  // Applies one instruction to the shadow state and queues the expected result.
  task automatic predict_step(input logic [3:0] c, input logic [31:0] v, input logic [7:0] s);
    int unsigned  need;
    logic [15:0]  nip;
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  r;
    logic [7:0]   ts;
    step_result_t res;
    need = 0;
    nip = shadow_ip + 16'd1;
    res.fault = sms_pkg::FAULT_OK;
    case (c)
      sms_pkg::OP_POP, sms_pkg::OP_JMP, sms_pkg::OP_DUP: need = 1;
      sms_pkg::OP_JMPIF, sms_pkg::OP_ADD, sms_pkg::OP_SUB, sms_pkg::OP_MUL,
      sms_pkg::OP_DIV, sms_pkg::OP_SWAP: need = 2;
      default: need = 0;
    endcase
    if (shadow_depth < need) begin
      res.fault = sms_pkg::FAULT_UNDR;
    end else if ((c == sms_pkg::OP_PUSH || c == sms_pkg::OP_DUP) && shadow_depth >= DEPTH) begin
      res.fault = sms_pkg::FAULT_OVER;
    end else if (c == sms_pkg::OP_DIV && shadow_value[shadow_depth-1] == 0) begin
      res.fault = sms_pkg::FAULT_DIV0;
    end else begin
      case (c)
        sms_pkg::OP_NOP: shadow_ip = nip;
        sms_pkg::OP_PUSH: begin
          shadow_value[shadow_depth] = v;
          shadow_symbol[shadow_depth] = s;
          shadow_depth++;
          shadow_ip = nip;
        end
        sms_pkg::OP_POP: begin
          shadow_depth--;
          shadow_ip = nip;
        end
        sms_pkg::OP_JMP: begin
          shadow_ip = shadow_value[shadow_depth-1][15:0];
          shadow_depth--;
        end
        sms_pkg::OP_JMPIF: begin
          shadow_ip = (shadow_value[shadow_depth-2] != 0) ?
                      shadow_value[shadow_depth-1][15:0] : nip;
          shadow_depth -= 2;
        end
        sms_pkg::OP_ADD, sms_pkg::OP_SUB, sms_pkg::OP_MUL, sms_pkg::OP_DIV: begin
          b = shadow_value[shadow_depth-1];
          a = shadow_value[shadow_depth-2];
          case (c)
            sms_pkg::OP_ADD: r = a + b;
            sms_pkg::OP_SUB: r = a - b;
            sms_pkg::OP_MUL: r = a * b;
            default:         r = quotient_trunc(a, b);
          endcase
          shadow_value[shadow_depth-2] = r;
          shadow_depth--;
          shadow_ip = nip;
        end
        sms_pkg::OP_DUP: begin
          shadow_value[shadow_depth] = shadow_value[shadow_depth-1];
          shadow_symbol[shadow_depth] = shadow_symbol[shadow_depth-1];
          shadow_depth++;
          shadow_ip = nip;
        end
        sms_pkg::OP_SWAP: begin
          r = shadow_value[shadow_depth-1];
          ts = shadow_symbol[shadow_depth-1];
          shadow_value[shadow_depth-1] = shadow_value[shadow_depth-2];
          shadow_symbol[shadow_depth-1] = shadow_symbol[shadow_depth-2];
          shadow_value[shadow_depth-2] = r;
          shadow_symbol[shadow_depth-2] = ts;
          shadow_ip = nip;
        end
        default: ;  // label, halt and invalid codes leave everything alone
      endcase
    end
    if (shadow_depth > 0) begin
      res.value = shadow_value[shadow_depth-1];
      res.symbol = shadow_symbol[shadow_depth-1];
    end else begin
      res.value = '0;
      res.symbol = '0;
    end
    res.count = shadow_depth[10:0];
    res.ip = shadow_ip;
    expected_steps.push_back(res);
  endtask

  // Sends one instruction; start stays high after the transfer until the next call.
  task automatic send_instr(input logic [3:0] c, input logic [31:0] v, input logic [7:0] s);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(7)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start = 1'b1;
    cmd_i = c;
    operand_value_i = v;
    operand_symbol_i = s;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_step(c, v, s);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(4) - 2;
      3: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    step_result_t exp_r;
    if (rst_ni && done_o) begin
      if (expected_steps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = expected_steps.pop_front();
        if (top_value_o !== exp_r.value || top_symbol_o !== exp_r.symbol ||
            stack_count_o !== exp_r.count || next_ip_o !== exp_r.ip ||
            fault_o !== exp_r.fault) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch at %0t: exp val %0d sym %0d cnt %0d ip %0d fault %0d,",
                      " got val %0d sym %0d cnt %0d ip %0d fault %0d"},
                     $realtime, exp_r.value, exp_r.symbol, exp_r.count, exp_r.ip,
                     exp_r.fault, top_value_o, top_symbol_o, stack_count_o, next_ip_o,
                     fault_o);
        end
      end
    end
  end

  task automatic test_empty_stack();
    send_instr(sms_pkg::OP_NOP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_LABEL, 32'd5, 8'd1);
    send_instr(sms_pkg::OP_HALT, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_INVALID, 32'd0, 8'd0);
    send_instr(4'd14, 32'd0, 8'd0);
    send_instr(4'd15, 32'hffff_ffff, 8'hff);
    send_instr(sms_pkg::OP_POP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_JMP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_DUP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_PUSH, 32'd7, 8'h00);
    send_instr(sms_pkg::OP_ADD, 32'd0, 8'd0);    // one entry is not enough for two operands
    send_instr(sms_pkg::OP_SWAP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_JMPIF, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_POP, 32'd0, 8'd0);
  endtask

  task automatic test_arith_extremes();
    send_instr(sms_pkg::OP_PUSH, 32'h7fff_ffff, 8'hff);
    send_instr(sms_pkg::OP_PUSH, 32'd1, 8'h01);
    send_instr(sms_pkg::OP_ADD, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_PUSH, 32'hffff_ffff, 8'h03);
    send_instr(sms_pkg::OP_DIV, 32'd0, 8'd0);    // most negative over minus one wraps
    send_instr(sms_pkg::OP_PUSH, 32'd1, 8'h02);
    send_instr(sms_pkg::OP_SUB, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_PUSH, 32'd0, 8'h04);
    send_instr(sms_pkg::OP_DIV, 32'd0, 8'd0);    // divide by zero leaves the stack alone
    send_instr(sms_pkg::OP_POP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_PUSH, 32'hffff_fff9, 8'h05);
    send_instr(sms_pkg::OP_DIV, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_PUSH, 32'h0001_0003, 8'h06);
    send_instr(sms_pkg::OP_MUL, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_DUP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_SWAP, 32'd0, 8'd0);
  endtask

  task automatic test_jumps();
    send_instr(sms_pkg::OP_PUSH, 32'h1234_ffff, 8'h10);
    send_instr(sms_pkg::OP_JMP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_NOP, 32'd0, 8'd0);    // pointer wraps to zero
    send_instr(sms_pkg::OP_PUSH, 32'd0, 8'h11);
    send_instr(sms_pkg::OP_PUSH, 32'd99, 8'h12);
    send_instr(sms_pkg::OP_JMPIF, 32'd0, 8'd0);  // zero condition falls through
    send_instr(sms_pkg::OP_PUSH, 32'h8000_0000, 8'h13);
    send_instr(sms_pkg::OP_PUSH, 32'd300, 8'h14);
    send_instr(sms_pkg::OP_JMPIF, 32'd0, 8'd0);
  endtask

  task automatic test_random(input int unsigned n, input int unsigned pct);
    logic [3:0] c;
    int unsigned roll;
    idle_pct = pct;
    repeat (n) begin
      roll = $urandom_range(99);
      if (shadow_depth < 2 && roll < 70) c = sms_pkg::OP_PUSH;
      else if (shadow_depth > 48 && roll < 50) c = sms_pkg::OP_POP;
      else if (roll < 30) c = sms_pkg::OP_PUSH;
      else if (roll < 55) c = 4'(sms_pkg::OP_ADD + $urandom_range(3));
      else if (roll < 65) c = ($urandom_range(1) != 0) ? sms_pkg::OP_DUP : sms_pkg::OP_SWAP;
      else if (roll < 73) c = sms_pkg::OP_POP;
      else if (roll < 82) c = ($urandom_range(1) != 0) ? sms_pkg::OP_JMP : sms_pkg::OP_JMPIF;
      else c = 4'($urandom_range(15));
      send_instr(c, rand_value(), 8'($urandom));
    end
    idle_pct = 0;
  endtask

  task automatic test_overflow();
    while (shadow_depth < DEPTH) send_instr(sms_pkg::OP_PUSH, $urandom, 8'($urandom));
    send_instr(sms_pkg::OP_PUSH, 32'd1, 8'd1);
    send_instr(sms_pkg::OP_DUP, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_ADD, 32'd0, 8'd0);
    send_instr(sms_pkg::OP_DUP, 32'd0, 8'd0);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = sms_pkg::OP_NOP;
    operand_value_i = '0;
    operand_symbol_i = '0;
    shadow_depth = 0;
    shadow_ip = '0;
    mismatch_count = 0;
    idle_pct = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_stack();
    test_arith_extremes();
    test_jumps();
    drain_results();
    test_random(240, 0);
    test_random(230, 52);
    drain_results();
    test_random(230, 18);
    test_overflow();

    @(negedge clk_i);
    start = 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sms_pkg.sv
rtl/core/sms_div.sv
rtl/core/sms_mem.sv
rtl/core/stack_machine_step_top.sv
rtl/core/sms_checker.sv
test/testbench.sv
